// ----- design/swdhte_pkg.sv -----
// ----------------------------------------------------------------------------
// SWD host engine package
// Shared types, codes and defaults for the SWD host transaction engine.
// ----------------------------------------------------------------------------
package swdhte_pkg;

  localparam int RESET_BITS_DEFAULT = 64;
  localparam int IDLE_BITS_DEFAULT  = 8;

  localparam logic [31:0] UNLOCK_KEY = 32'h0000_E79E;

  localparam logic [2:0] ACK_OK    = 3'b001;
  localparam logic [2:0] ACK_WAIT  = 3'b010;
  localparam logic [2:0] ACK_FAULT = 3'b100;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_FAULT  = 3'd2;
  localparam logic [2:0] ST_PARITY = 3'd3;
  localparam logic [2:0] ST_PROTO  = 3'd4;

  localparam logic [1:0] REQ_READ    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_CONNECT = 2'd2;

  typedef logic [1:0] swdhte_kind_t;

  typedef struct packed {
    logic        start_req;
    logic [1:0]  req_type;
    logic        ap_ndp;
    logic [1:0]  addr;
    logic [31:0] wdata;
    logic        swdio_in;
  } swdhte_item_t;

  // Classified bit period handed from the front to the engine
  typedef struct packed {
    logic         start;
    swdhte_kind_t kind;
    logic         ap_ndp;
    logic [1:0]   addr;
    logic [31:0]  wdata;
    logic         din;
  } swdhte_cmd_t;

  typedef struct packed {
    logic        swdio_out;
    logic        swdio_oe;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  ack;
    logic [2:0]  status;
    logic [31:0] rdata;
  } swdhte_result_t;

endpackage

// ----- design/swd_host_transaction_engine_core.sv -----
// ----------------------------------------------------------------------------
// SWD host transaction engine
// One beat in is one SWCLK bit period; one beat out is that period's result.
// ----------------------------------------------------------------------------
//  channel   direction   handshake            payload
//  item      in          push / full          swdhte_item_t
//  result    out         pop / empty          swdhte_result_t
//
// The sequencer handles each beat combinationally and takes one beat per clock,
// sustained when the result side keeps popping.
// A beat is registered in the command queue and its result in the result
// queue on the way to the output, where the result can then be popped.
// Synchronous reset returns the sequencer to idle and empties both queues.
// A full result queue stalls the sequencer, which in turn fills the command
// queue and raises full.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine_core
  import swdhte_pkg::*;
#(
  parameter int RESET_BITS = RESET_BITS_DEFAULT,
  parameter int IDLE_BITS  = IDLE_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  swdhte_item_t   item,
  output logic           empty,
  input  logic           pop,
  output swdhte_result_t result
);

  swdhte_cmd_t    cmd;
  swdhte_result_t res;
  logic           cmd_valid;
  logic           cmd_take;
  logic           res_valid;
  logic           res_full;

  swdhte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd)
  );

  swdhte_engine #(
    .RESET_BITS(RESET_BITS),
    .IDLE_BITS (IDLE_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .res_room (!res_full),
    .res_valid(res_valid),
    .res      (res)
  );

  swdhte_fifo #(
    .WIDTH($bits(swdhte_result_t))
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_valid),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(result),
    .empty  (empty)
  );

endmodule

// ----- design/swdhte_fifo.sv -----
// ----------------------------------------------------------------------------
// SWD host engine two-entry queue
// Small registered queue used between the front, the engine and the output.
// ----------------------------------------------------------------------------
module swdhte_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [0:0]       wr_ptr;
  logic [0:0]       rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == 2'(DEPTH));
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

// ----- design/swdhte_front.sv -----
// ----------------------------------------------------------------------------
// SWD host engine front end
// Accepts bit periods, decodes the request kind and queues them.
// ----------------------------------------------------------------------------
module swdhte_front
  import swdhte_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  swdhte_item_t item,
  output logic         cmd_valid,
  input  logic         cmd_take,
  output swdhte_cmd_t  cmd
);

  swdhte_cmd_t  cmd_in;
  swdhte_kind_t kind;
  logic         q_empty;

  // Type code 3 runs as a read
  always_comb begin
    unique case (item.req_type)
      REQ_WRITE:   kind = REQ_WRITE;
      REQ_CONNECT: kind = REQ_CONNECT;
      default:     kind = REQ_READ;
    endcase
  end

  assign cmd_in.start  = item.start_req;
  assign cmd_in.kind   = kind;
  assign cmd_in.ap_ndp = item.ap_ndp;
  assign cmd_in.addr   = item.addr;
  assign cmd_in.wdata  = item.wdata;
  assign cmd_in.din    = item.swdio_in;

  swdhte_fifo #(
    .WIDTH($bits(swdhte_cmd_t))
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(cmd_in),
    .full   (full),
    .rd_en  (cmd_take),
    .rd_data(cmd),
    .empty  (q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

// ----- design/swdhte_engine.sv -----
// ----------------------------------------------------------------------------
// SWD host engine sequencer
// Runs one bit period of the SWD transaction state machine per beat.
// ----------------------------------------------------------------------------
module swdhte_engine
  import swdhte_pkg::*;
#(
  parameter int RESET_BITS = RESET_BITS_DEFAULT,
  parameter int IDLE_BITS  = IDLE_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  swdhte_cmd_t    cmd,
  output logic           cmd_take,
  input  logic           res_room,
  output logic           res_valid,
  output swdhte_result_t res
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_CRST1  = 4'd1;
  localparam logic [3:0] PH_CKEY   = 4'd2;
  localparam logic [3:0] PH_CRST2  = 4'd3;
  localparam logic [3:0] PH_CIDLE  = 4'd4;
  localparam logic [3:0] PH_HDR    = 4'd5;
  localparam logic [3:0] PH_TRN    = 4'd6;
  localparam logic [3:0] PH_ACK    = 4'd7;
  localparam logic [3:0] PH_RDATA  = 4'd8;
  localparam logic [3:0] PH_RTRN   = 4'd9;
  localparam logic [3:0] PH_WTRN   = 4'd10;
  localparam logic [3:0] PH_WDATA  = 4'd11;
  localparam logic [3:0] PH_TAIL   = 4'd12;
  localparam logic [3:0] PH_SHORT  = 4'd13;
  localparam logic [3:0] PH_EAT    = 4'd14;

  localparam logic [6:0] RST_LIM  = 7'(RESET_BITS);
  localparam logic [6:0] IDLE_LIM = 7'(IDLE_BITS);
  localparam logic [6:0] WORD_LIM = 7'd32;
  localparam logic [6:0] DATA_LIM = 7'd33;
  localparam logic [6:0] HDR_LIM  = 7'd9;
  localparam logic [6:0] ACK_LIM  = 7'd3;

  logic [3:0]   phase,        phase_next;
  logic [6:0]   bit_count,    bit_count_next;
  logic [31:0]  shift_word,   shift_word_next;
  logic         parity_acc,   parity_acc_next;
  logic [2:0]   ack_reg,      ack_reg_next;
  swdhte_kind_t latched_type, latched_type_next;
  logic         latched_ap,   latched_ap_next;
  logic [1:0]   latched_addr, latched_addr_next;

  logic [6:0] bc_inc;
  logic       rnw;
  logic       finish;
  logic       step;

  assign step      = cmd_valid && res_room;
  assign cmd_take  = step;
  assign res_valid = step;

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_word_next   = shift_word;
    parity_acc_next   = parity_acc;
    ack_reg_next      = ack_reg;
    latched_type_next = latched_type;
    latched_ap_next   = latched_ap;
    latched_addr_next = latched_addr;
    finish            = 1'b0;
    res               = '0;
    res.swdio_out     = 1'b1;
    res.swdio_oe      = 1'b1;

    // The starting period is already the first bit of the transaction
    if (phase == PH_IDLE || phase > PH_EAT) begin
      phase_next = PH_IDLE;
      if (cmd.start) begin
        latched_type_next = cmd.kind;
        ack_reg_next      = '0;
        parity_acc_next   = 1'b0;
        bit_count_next    = '0;
        if (cmd.kind == REQ_CONNECT) begin
          latched_ap_next   = 1'b0;
          latched_addr_next = '0;
          shift_word_next   = UNLOCK_KEY;
          phase_next        = PH_CRST1;
        end else begin
          latched_ap_next   = cmd.ap_ndp;
          latched_addr_next = cmd.addr;
          shift_word_next   = cmd.wdata;
          phase_next        = PH_HDR;
        end
      end
    end

    bc_inc = bit_count_next + 7'd1;
    rnw    = (latched_type_next != REQ_WRITE);

    if (phase_next != PH_IDLE) begin
      res.busy_res = 1'b1;
      unique case (phase_next)
        PH_CRST1, PH_CRST2: begin
          res.swdio_out = 1'b1;
          if (bc_inc >= RST_LIM) begin
            bit_count_next = '0;
            phase_next     = (phase_next == PH_CRST1) ? PH_CKEY : PH_CIDLE;
          end else begin
            bit_count_next = bc_inc;
          end
        end
        PH_CKEY: begin
          res.swdio_out   = shift_word_next[0];
          shift_word_next = {1'b0, shift_word_next[31:1]};
          if (bc_inc >= WORD_LIM) begin
            bit_count_next = '0;
            phase_next     = PH_CRST2;
          end else begin
            bit_count_next = bc_inc;
          end
        end
        PH_CIDLE: begin
          res.swdio_out = 1'b0;
          if (bc_inc >= IDLE_LIM) begin
            bit_count_next = '0;
            phase_next     = PH_HDR;
          end else begin
            bit_count_next = bc_inc;
          end
        end
        PH_HDR: begin
          unique case (bit_count_next)
            7'd0:    res.swdio_out = 1'b0;
            7'd1:    res.swdio_out = 1'b1;
            7'd2:    res.swdio_out = latched_ap_next;
            7'd3:    res.swdio_out = rnw;
            7'd4:    res.swdio_out = latched_addr_next[0];
            7'd5:    res.swdio_out = latched_addr_next[1];
            7'd6:    res.swdio_out = latched_ap_next ^ rnw ^ latched_addr_next[0]
                                     ^ latched_addr_next[1];
            7'd7:    res.swdio_out = 1'b0;
            default: res.swdio_out = 1'b1;
          endcase
          if (bc_inc >= HDR_LIM) begin
            bit_count_next = '0;
            phase_next     = PH_TRN;
          end else begin
            bit_count_next = bc_inc;
          end
        end
        PH_TRN: begin
          res.swdio_oe   = 1'b0;
          res.swdio_out  = 1'b0;
          bit_count_next = '0;
          phase_next     = PH_ACK;
        end
        PH_ACK: begin
          res.swdio_oe  = 1'b0;
          res.swdio_out = 1'b0;
          if (bit_count_next < ACK_LIM) begin
            ack_reg_next[bit_count_next[1:0]] = ack_reg_next[bit_count_next[1:0]] | cmd.din;
          end
          if (bc_inc >= ACK_LIM) begin
            bit_count_next = '0;
            if (ack_reg_next == ACK_OK) begin
              if (latched_type_next == REQ_WRITE) begin
                phase_next = PH_WTRN;
              end else begin
                shift_word_next = '0;
                phase_next      = PH_RDATA;
              end
            end else if (ack_reg_next == ACK_WAIT || ack_reg_next == ACK_FAULT) begin
              phase_next = PH_SHORT;
            end else begin
              phase_next = PH_EAT;
            end
          end else begin
            bit_count_next = bc_inc;
          end
        end
        PH_RDATA: begin
          res.swdio_oe  = 1'b0;
          res.swdio_out = 1'b0;
          if (bit_count_next < WORD_LIM) begin
            shift_word_next = {cmd.din, shift_word_next[31:1]};
          end
          parity_acc_next = parity_acc_next ^ cmd.din;
          if (bc_inc >= DATA_LIM) begin
            bit_count_next = '0;
            phase_next     = PH_RTRN;
          end else begin
            bit_count_next = bc_inc;
          end
        end
        PH_RTRN: begin
          res.swdio_out = 1'b0;
          phase_next    = PH_TAIL;
        end
        PH_WTRN: begin
          res.swdio_oe    = 1'b0;
          res.swdio_out   = 1'b0;
          parity_acc_next = 1'b0;
          phase_next      = PH_WDATA;
        end
        PH_WDATA: begin
          if (bit_count_next < WORD_LIM) begin
            res.swdio_out   = shift_word_next[0];
            parity_acc_next = parity_acc_next ^ shift_word_next[0];
            shift_word_next = {1'b0, shift_word_next[31:1]};
          end else begin
            res.swdio_out   = parity_acc_next;
            parity_acc_next = 1'b0;
          end
          if (bc_inc >= DATA_LIM) begin
            bit_count_next = '0;
            phase_next     = PH_TAIL;
          end else begin
            bit_count_next = bc_inc;
          end
        end
        PH_TAIL: begin
          res.swdio_out = 1'b0;
          if (bc_inc >= IDLE_LIM) begin
            bit_count_next = '0;
            finish         = 1'b1;
          end else begin
            bit_count_next = bc_inc;
          end
        end
        PH_SHORT: begin
          res.swdio_oe  = 1'b0;
          res.swdio_out = 1'b0;
          finish        = 1'b1;
        end
        default: begin
          // Protocol error: discard the data phase
          res.swdio_oe  = 1'b0;
          res.swdio_out = 1'b0;
          if (bc_inc >= DATA_LIM) begin
            bit_count_next = '0;
            phase_next     = PH_TAIL;
          end else begin
            bit_count_next = bc_inc;
          end
        end
      endcase
    end

    if (finish) begin
      res.done_res = 1'b1;
      res.ack      = ack_reg_next;
      priority if (ack_reg_next == ACK_OK) begin
        res.status = parity_acc_next ? ST_PARITY : ST_OK;
      end else if (ack_reg_next == ACK_WAIT) begin
        res.status = ST_WAIT;
      end else if (ack_reg_next == ACK_FAULT) begin
        res.status = ST_FAULT;
      end else begin
        res.status = ST_PROTO;
      end
      if (ack_reg_next == ACK_OK && latched_type_next != REQ_WRITE) begin
        res.rdata = shift_word_next;
      end
      phase_next     = PH_IDLE;
      bit_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      shift_word   <= '0;
      parity_acc   <= 1'b0;
      ack_reg      <= '0;
      latched_type <= REQ_READ;
      latched_ap   <= 1'b0;
      latched_addr <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_word   <= shift_word_next;
      parity_acc   <= parity_acc_next;
      ack_reg      <= ack_reg_next;
      latched_type <= latched_type_next;
      latched_ap   <= latched_ap_next;
      latched_addr <= latched_addr_next;
    end
  end

endmodule
